### sv/fker_pkg.sv
package fker_pkg;

	localparam int HOLD_DEPTH    = 16;
	localparam int NUM_SEQUENCES = 33;
	localparam int SEQ_LENGTH    = 6;
	localparam int ROM_SIZE      = 33;
	localparam int NUM_LANES     = (NUM_SEQUENCES < ROM_SIZE) ? NUM_SEQUENCES : ROM_SIZE;

	localparam int DEPTH_W   = $clog2(HOLD_DEPTH);
	localparam int CODE_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BASE = 2'd2;

	localparam logic [1:0] GRP_LEFT  = 2'd0;
	localparam logic [1:0] GRP_TOP   = 2'd1;
	localparam logic [1:0] GRP_RIGHT = 2'd2;

	localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1b;
	localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5b;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_Z        = 8'h7a;

	// sequence number stored as its three decimal digits
	typedef struct packed {
		logic [1:0] group;
		logic [3:0] key;
		logic [3:0] d100;
		logic [3:0] d10;
		logic [3:0] d1;
	} rom_entry_t;

	localparam rom_entry_t SEQ_ROM [ROM_SIZE] = '{
		'{GRP_LEFT,  4'd2,  4'd1, 4'd9, 4'd3}, '{GRP_LEFT,  4'd3,  4'd1, 4'd9, 4'd4},
		'{GRP_LEFT,  4'd4,  4'd1, 4'd9, 4'd5}, '{GRP_LEFT,  4'd5,  4'd1, 4'd9, 4'd6},
		'{GRP_LEFT,  4'd6,  4'd1, 4'd9, 4'd7}, '{GRP_LEFT,  4'd7,  4'd1, 4'd9, 4'd8},
		'{GRP_LEFT,  4'd8,  4'd1, 4'd9, 4'd9}, '{GRP_LEFT,  4'd9,  4'd2, 4'd0, 4'd0},
		'{GRP_LEFT,  4'd10, 4'd2, 4'd0, 4'd1},
		'{GRP_TOP,   4'd1,  4'd2, 4'd2, 4'd4}, '{GRP_TOP,   4'd2,  4'd2, 4'd2, 4'd5},
		'{GRP_TOP,   4'd3,  4'd2, 4'd2, 4'd6}, '{GRP_TOP,   4'd4,  4'd2, 4'd2, 4'd7},
		'{GRP_TOP,   4'd5,  4'd2, 4'd2, 4'd8}, '{GRP_TOP,   4'd6,  4'd2, 4'd2, 4'd9},
		'{GRP_TOP,   4'd7,  4'd2, 4'd3, 4'd0}, '{GRP_TOP,   4'd8,  4'd2, 4'd3, 4'd1},
		'{GRP_TOP,   4'd9,  4'd2, 4'd3, 4'd2},
		'{GRP_RIGHT, 4'd1,  4'd2, 4'd0, 4'd8}, '{GRP_RIGHT, 4'd2,  4'd2, 4'd0, 4'd9},
		'{GRP_RIGHT, 4'd3,  4'd2, 4'd1, 4'd0}, '{GRP_RIGHT, 4'd4,  4'd2, 4'd1, 4'd1},
		'{GRP_RIGHT, 4'd5,  4'd2, 4'd1, 4'd2}, '{GRP_RIGHT, 4'd6,  4'd2, 4'd1, 4'd3},
		'{GRP_RIGHT, 4'd7,  4'd2, 4'd1, 4'd4}, '{GRP_RIGHT, 4'd8,  4'd2, 4'd1, 4'd5},
		'{GRP_RIGHT, 4'd9,  4'd2, 4'd1, 4'd6}, '{GRP_RIGHT, 4'd10, 4'd2, 4'd1, 4'd7},
		'{GRP_RIGHT, 4'd11, 4'd2, 4'd1, 4'd8}, '{GRP_RIGHT, 4'd12, 4'd2, 4'd1, 4'd9},
		'{GRP_RIGHT, 4'd13, 4'd2, 4'd2, 4'd0}, '{GRP_RIGHT, 4'd14, 4'd2, 4'd2, 4'd1},
		'{GRP_RIGHT, 4'd15, 4'd2, 4'd2, 4'd2}
	};

	// {valid, char} expected at position pos of a sequence
	function automatic logic [CHAR_W:0] seq_char(rom_entry_t e, logic [DEPTH_W-1:0] pos);
		logic [CHAR_W:0] r;
		r = '0;
		if ({1'b0, pos} < (DEPTH_W+1)'(SEQ_LENGTH)) begin
			case (pos)
				DEPTH_W'(0): r = {1'b1, CH_ESC};
				DEPTH_W'(1): r = {1'b1, CH_LBRACKET};
				DEPTH_W'(2): r = {1'b1, CH_ZERO + {4'b0, e.d100}};
				DEPTH_W'(3): r = {1'b1, CH_ZERO + {4'b0, e.d10}};
				DEPTH_W'(4): r = {1'b1, CH_ZERO + {4'b0, e.d1}};
				DEPTH_W'(5): r = {1'b1, CH_Z};
				default:     r = '0;
			endcase
		end
		return r;
	endfunction

	typedef enum logic [1:0] {
		SRC_HELD,
		SRC_EVENT,
		SRC_KEY
	} src_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic              is_char;
		logic              key_down;
	} ev_t;

	typedef struct packed {
		logic [CODE_W-1:0] out_code;
		logic              out_is_char;
		logic              out_down;
		logic              overflow;
		logic              last;
	} res_t;

	typedef struct packed {
		logic load;
		logic hold;
		logic restart;
		logic emit;
		src_t src;
		logic last;
		logic ovf;
	} fker_cmd_t;

	typedef struct packed {
		logic is_char;
		logic down;
		logic any;
		logic complete;
		logic full;
		logic flush_done;
		logic flush_last;
		logic out_free;
	} fker_status_t;

endpackage

### sv/fker_ctrl.sv
module fker_ctrl import fker_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ev_valid,
	output logic         ev_ready,
	input  fker_status_t status,
	output fker_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_FLUSH,
		S_TAIL
	} state_t;

	state_t state_q, state_d;
	logic   tail_q, tail_d;
	src_t   tail_src_q, tail_src_d;
	logic   ovf_q, ovf_d;

	assign ev_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.src    = SRC_HELD;
		state_d    = state_q;
		tail_d     = tail_q;
		tail_src_d = tail_src_q;
		ovf_d      = ovf_q;
		unique case (state_q)
			S_IDLE: begin
				if (ev_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				tail_d     = 1'b1;
				tail_src_d = SRC_EVENT;
				ovf_d      = 1'b0;
				state_d    = S_FLUSH;
				if (!status.is_char) begin
					// flush, then forward the event
				end else if (!status.down) begin
					tail_d = 1'b0;
				end else if (!status.any) begin
					// mismatch: flush, then the character
				end else if (status.complete) begin
					tail_src_d = SRC_KEY;
					state_d    = S_TAIL;
				end else if (status.full) begin
					ovf_d = 1'b1;
				end else begin
					cmd.hold = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_FLUSH: begin
				cmd.src  = SRC_HELD;
				cmd.ovf  = ovf_q;
				cmd.last = !tail_q && status.flush_last;
				if (status.flush_done) begin
					cmd.restart = 1'b1;
					state_d     = tail_q ? S_TAIL : S_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
				end
			end
			S_TAIL: begin
				cmd.src  = tail_src_q;
				cmd.ovf  = ovf_q;
				cmd.last = 1'b1;
				if (status.out_free) begin
					cmd.emit    = 1'b1;
					cmd.restart = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tail_q     <= 1'b0;
			tail_src_q <= SRC_EVENT;
			ovf_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			tail_q     <= tail_d;
			tail_src_q <= tail_src_d;
			ovf_q      <= ovf_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result emitted over a pending result");

	a_hold_partial: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold |-> (status.is_char && status.down && status.any
			&& !status.complete && !status.full))
		else $error("character held without a partial match");

endmodule

### sv/fker_dp.sv
module fker_dp import fker_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ev_t                  ev_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data,
	input  fker_cmd_t            cmd,
	output fker_status_t         status
);

	ev_t                  item_q;
	logic [NUM_LANES-1:0] mask_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   rd_ptr_q;
	logic [CHAR_W-1:0]    held_q [HOLD_DEPTH];
	logic [1:0]           hit_grp_q;
	logic [3:0]           hit_key_q;
	logic [CODE_W-1:0]    left_base_q, top_base_q, right_base_q;
	res_t                 res_q;
	logic                 res_valid_q;

	logic [NUM_LANES-1:0] mask_new;
	logic [1:0]           hit_grp;
	logic [3:0]           hit_key;
	logic                 any_hit, uniq_hit;
	logic [CODE_W-1:0]    grp_base, key_code;
	res_t                 res_d;

	// one comparator lane per ROM sequence, all at the current position
	always_comb begin
		logic [CHAR_W:0] expc;
		hit_grp = '0;
		hit_key = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			expc = seq_char(SEQ_ROM[i], depth_q);
			mask_new[i] = mask_q[i] && expc[CHAR_W]
				&& (item_q.event_code == CODE_W'(expc[CHAR_W-1:0]));
			hit_grp = hit_grp | (mask_new[i] ? SEQ_ROM[i].group : 2'b0);
			hit_key = hit_key | (mask_new[i] ? SEQ_ROM[i].key : 4'b0);
		end
	end

	assign any_hit  = |mask_new;
	assign uniq_hit = any_hit && ((mask_new & (mask_new - 1'b1)) == '0);

	assign status.is_char    = item_q.is_char;
	assign status.down       = item_q.key_down;
	assign status.any        = any_hit;
	assign status.complete   = uniq_hit
		&& ({1'b0, depth_q} == (DEPTH_W+1)'(SEQ_LENGTH - 1));
	assign status.full       = (depth_q == DEPTH_W'(HOLD_DEPTH - 1));
	assign status.flush_done = (rd_ptr_q == depth_q);
	assign status.flush_last = (({1'b0, rd_ptr_q} + 1'b1) == {1'b0, depth_q});
	assign status.out_free   = !res_valid_q || res_ready;

	always_comb begin
		unique case (hit_grp_q)
			GRP_LEFT: grp_base = left_base_q;
			GRP_TOP:  grp_base = top_base_q;
			default:  grp_base = right_base_q;
		endcase
	end

	assign key_code = grp_base + CODE_W'(hit_key_q) - CODE_W'(1);

	always_comb begin
		res_d          = '0;
		res_d.overflow = cmd.ovf;
		res_d.last     = cmd.last;
		case (cmd.src)
			SRC_HELD: begin
				res_d.out_code    = CODE_W'(held_q[rd_ptr_q]);
				res_d.out_is_char = 1'b1;
				res_d.out_down    = 1'b1;
			end
			SRC_EVENT: begin
				res_d.out_code    = item_q.event_code;
				res_d.out_is_char = item_q.is_char;
				res_d.out_down    = item_q.key_down;
			end
			SRC_KEY: begin
				res_d.out_code    = key_code;
				res_d.out_is_char = 1'b0;
				res_d.out_down    = 1'b1;
			end
			default: res_d.out_code = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= ev_data;
		end
		if (cmd.hold) begin
			held_q[depth_q] <= item_q.event_code[CHAR_W-1:0];
		end
		if (cmd.emit) begin
			res_q <= res_d;
		end
		// item is stable from decide through tail, so this settles in time
		hit_grp_q <= hit_grp;
		hit_key_q <= hit_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '1;
			depth_q      <= '0;
			rd_ptr_q     <= '0;
			res_valid_q  <= 1'b0;
			left_base_q  <= '0;
			top_base_q   <= '0;
			right_base_q <= '0;
		end else begin
			if (cmd.restart) begin
				mask_q   <= '1;
				depth_q  <= '0;
				rd_ptr_q <= '0;
			end else begin
				if (cmd.hold) begin
					mask_q  <= mask_new;
					depth_q <= depth_q + 1'b1;
				end
				if (cmd.emit && cmd.src == SRC_HELD) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LEFT_BASE:  left_base_q  <= cfg_data;
					REG_TOP_BASE:   top_base_q   <= cfg_data;
					REG_RIGHT_BASE: right_base_q <= cfg_data;
					default:        ;
				endcase
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= depth_q)
		else $error("flush pointer ran past held count");

	a_mask_live: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q != '0)
		else $error("held characters with no candidate left");

	a_depth_seq: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, depth_q} < (DEPTH_W+1)'(SEQ_LENGTH))
		else $error("held more characters than a sequence has");

endmodule

### sv/function_key_escape_recognizer_top.sv
// Function-key escape recognizer. Keyboard events come in on ev_* and results
// leave on res_*. Character key-downs that follow one of 33 sequences ESC [ n n n z
// are held back; a complete sequence turns into one function-key event whose code
// is the group base register plus key number minus one. Anything else releases
// the held characters in order, followed by the event itself (a character key-up
// is dropped). The controller handles one item at a time: ev_ready is high only
// in idle, so a new event is accepted only after the last one is fully handled.
// Results leave one per cycle when the output is taken at once; a result that
// res_ready holds off stalls the controller until it is taken. Group bases are
// written through cfg_we/cfg_index/cfg_data while no request is in flight; the
// user must ensure this, as the block itself does not enforce it.
module function_key_escape_recognizer_top import fker_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	output logic                 ev_ready,
	input  ev_t                  ev_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]    cfg_data
);

	fker_cmd_t    cmd;
	fker_status_t status;

	fker_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_ready (ev_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fker_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_data   (ev_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

### tb/tb_function_key_escape_recognizer_top.sv
module tb_function_key_escape_recognizer_top;
	import fker_pkg::*;

	localparam int ESC_SEQ_COUNT    = 33;
	localparam int ESC_SEQ_LEN      = 6;
	localparam int HOLD_LIMIT       = 16;
	localparam int KEY_ESC          = 27;
	localparam int KEY_LBRACKET     = 91;
	localparam int DIGIT_ZERO       = 48;
	localparam int KEY_Z            = 122;
	localparam int SETTLE_CYCLES    = 12;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_PER_PHASE = 56;
	localparam int REPORT_LIMIT     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		LEFT_KEYS,
		TOP_KEYS,
		RIGHT_KEYS
	} key_group_e;

	class keyseq_scoreboard;
		logic [CODE_W-1:0]        group_base [3];
		logic [ESC_SEQ_COUNT-1:0] live_mask;
		int unsigned              held_count;
		logic [7:0]               held_chars [HOLD_LIMIT];
		int unsigned              seq_number [ESC_SEQ_COUNT];
		key_group_e               seq_group [ESC_SEQ_COUNT];
		int unsigned              seq_key [ESC_SEQ_COUNT];
		res_t                     step_q [$];
		res_t                     expected_q [$];
		int                       errors;

		function new();
			for (int i = 0; i < 9; i++) begin
				seq_number[i] = 193 + i;
				seq_group[i]  = LEFT_KEYS;
				seq_key[i]    = i + 2;
				seq_number[i + 9] = 224 + i;
				seq_group[i + 9]  = TOP_KEYS;
				seq_key[i + 9]    = i + 1;
			end
			for (int i = 0; i < 15; i++) begin
				seq_number[i + 18] = 208 + i;
				seq_group[i + 18]  = RIGHT_KEYS;
				seq_key[i + 18]    = i + 1;
			end
			group_base = '{default: '0};
			live_mask  = '1;
			held_count = 0;
			errors     = 0;
		endfunction

		function int escape_char(int idx, int unsigned pos);
			case (pos)
				0:       return KEY_ESC;
				1:       return KEY_LBRACKET;
				2:       return DIGIT_ZERO + (seq_number[idx] / 100) % 10;
				3:       return DIGIT_ZERO + (seq_number[idx] / 10) % 10;
				4:       return DIGIT_ZERO + seq_number[idx] % 10;
				5:       return KEY_Z;
				default: return -1;
			endcase
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] val);
			case (idx)
				REG_LEFT_BASE:  group_base[LEFT_KEYS]  = val;
				REG_TOP_BASE:   group_base[TOP_KEYS]   = val;
				REG_RIGHT_BASE: group_base[RIGHT_KEYS] = val;
				default: ;
			endcase
		endfunction

		function void add_result(logic [CODE_W-1:0] code, logic ch, logic dn, logic ovf);
			res_t r;
			r.out_code    = code;
			r.out_is_char = ch;
			r.out_down    = dn;
			r.overflow    = ovf;
			r.last        = 1'b0;
			step_q.push_back(r);
		endfunction

		function void release_held(logic ovf);
			for (int k = 0; k < held_count; k++)
				add_result({8'h00, held_chars[k]}, 1'b1, 1'b1, ovf);
			held_count = 0;
			live_mask  = '1;
		endfunction

		function void note_request(ev_t e);
			int   hits;
			int   hit;
			res_t r;
			hits = 0;
			hit  = 0;
			step_q.delete();
			if (!e.is_char) begin
				release_held(1'b0);
				add_result(e.event_code, 1'b0, e.key_down, 1'b0);
			end else if (!e.key_down) begin
				release_held(1'b0);
			end else begin
				for (int i = 0; i < ESC_SEQ_COUNT; i++) begin
					if (live_mask[i] && escape_char(i, held_count) == int'(e.event_code)) begin
						hits++;
						hit = i;
					end else begin
						live_mask[i] = 1'b0;
					end
				end
				if (hits == 0) begin
					release_held(1'b0);
					add_result(e.event_code, 1'b1, 1'b1, 1'b0);
				end else if (hits == 1 && held_count + 1 == ESC_SEQ_LEN) begin
					held_count = 0;
					live_mask  = '1;
					add_result(CODE_W'(group_base[seq_group[hit]] + seq_key[hit] - 1),
						1'b0, 1'b1, 1'b0);
				end else if (held_count + 1 >= HOLD_LIMIT) begin
					release_held(1'b1);
					add_result(e.event_code, 1'b1, 1'b1, 1'b1);
				end else begin
					held_chars[held_count] = e.event_code[7:0];
					held_count++;
				end
			end
			foreach (step_q[k]) begin
				r = step_q[k];
				r.last = (k == step_q.size() - 1);
				expected_q.push_back(r);
			end
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s", $time, what);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected result code %h char %b down %b ovf %b last %b",
					got.out_code, got.out_is_char, got.out_down, got.overflow, got.last));
				return;
			end
			want = expected_q.pop_front();
			if (got.out_code !== want.out_code || got.out_is_char !== want.out_is_char ||
			    got.out_down !== want.out_down || got.overflow !== want.overflow ||
			    got.last !== want.last)
				flag($sformatf({"mismatch exp/act: code %h/%h char %b/%b down %b/%b ",
					"ovf %b/%b last %b/%b"},
					want.out_code, got.out_code, want.out_is_char, got.out_is_char,
					want.out_down, got.out_down, want.overflow, got.overflow,
					want.last, got.last));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int close_out();
			if (expected_q.size() != 0)
				flag($sformatf("%0d results never arrived", expected_q.size()));
			return errors;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 ev_valid;
	logic                 ev_ready;
	ev_t                  ev_data;
	logic                 res_valid;
	logic                 res_ready;
	res_t                 res_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0]    cfg_data;

	keyseq_scoreboard board = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int ready_hold_cycles = 0;
	int cycle_count = 0;

	function_key_escape_recognizer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_ready  (ev_ready),
		.ev_data   (ev_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: a long hold-off request overrides the random stalls
	initial begin
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				board.check_result(res_data);
			if (ready_hold_cycles > 0) begin
				res_ready <= 1'b0;
				ready_hold_cycles--;
			end else begin
				res_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_event(input logic [CODE_W-1:0] code, input logic ch, input logic dn);
		ev_t e;
		e.event_code = code;
		e.is_char    = ch;
		e.key_down   = dn;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			ev_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		ev_valid <= 1'b1;
		ev_data  <= e;
		do @(posedge clk); while (!ev_ready);
		board.note_request(e);
	endtask

	// first count characters of a sequence, one of them replaced when bad is in range
	task automatic send_prefix(input int idx, input int count, input int bad);
		logic [CODE_W-1:0] c;
		for (int p = 0; p < count; p++) begin
			c = CODE_W'(board.escape_char(idx, p));
			if (p == bad)
				c = ($urandom_range(3) == 0) ? CODE_W'($urandom_range(65535))
				                             : CODE_W'($urandom_range(255));
			send_event(c, 1'b1, 1'b1);
		end
	endtask

	task automatic send_noise();
		logic [CODE_W-1:0] code;
		code = ($urandom_range(3) == 0) ? CODE_W'($urandom_range(65535))
		                                : CODE_W'($urandom_range(255));
		send_event(code, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic send_escape(output int n);
		int idx;
		int kind;
		int count;
		int bad;
		idx   = $urandom_range(ESC_SEQ_COUNT - 1);
		kind  = $urandom_range(99);
		count = (kind < 70) ? ESC_SEQ_LEN : $urandom_range(ESC_SEQ_LEN - 1, 1);
		bad   = (kind >= 85) ? $urandom_range(count - 1) : -1;
		send_prefix(idx, count, bad);
		n = count;
		if (kind >= 70 && $urandom_range(1) == 1) begin
			send_noise();
			n++;
		end
	endtask

	task automatic random_traffic(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 65) begin
				send_escape(k);
				sent += k;
			end else begin
				send_noise();
				sent++;
			end
		end
	endtask

	task automatic wait_drained();
		ev_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_register(idx, val);
	endtask

	task automatic write_bases(input logic [CODE_W-1:0] left_v, input logic [CODE_W-1:0] top_v,
		input logic [CODE_W-1:0] right_v);
		write_reg(REG_LEFT_BASE, left_v);
		write_reg(REG_TOP_BASE, top_v);
		write_reg(REG_RIGHT_BASE, right_v);
	endtask

	initial begin
		ev_valid  <= 1'b0;
		ev_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_bases(CODE_W'($urandom_range(65535)), CODE_W'($urandom_range(65535)),
			CODE_W'($urandom_range(65535)));
		write_reg(REG_UNUSED, CODE_W'($urandom_range(65535)));

		// directed: field extremes, lone key-up, wide char code, full matches, flushes
		send_event(16'h0000, 1'b0, 1'b0);
		send_event(16'hffff, 1'b0, 1'b1);
		send_event(16'h0061, 1'b1, 1'b0);
		send_event(16'h00ff, 1'b1, 1'b1);
		send_event(16'hffff, 1'b1, 1'b1);
		send_prefix(0, ESC_SEQ_LEN, -1);
		send_prefix(17, ESC_SEQ_LEN, -1);
		send_prefix(20, 3, -1);
		send_event(16'h0032, 1'b1, 1'b0);
		send_prefix(5, 1, -1);
		send_event(16'h0071, 1'b1, 1'b1);
		send_prefix(30, 2, -1);
		send_event(16'h8001, 1'b0, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					write_bases(16'hffff, 16'hffff, 16'hffff);
				end
				1: begin
					send_idle_pct = 83;
					stall_pct     = 0;
					write_bases(16'h0000, 16'h0000, 16'h0000);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 83;
					write_bases(CODE_W'($urandom_range(65535)), CODE_W'($urandom_range(65535)),
						CODE_W'($urandom_range(65535)));
				end
				default: begin
					send_idle_pct = 31;
					stall_pct     = 31;
					write_bases(16'h0000, 16'hffff, CODE_W'($urandom_range(65535)));
				end
			endcase
			if (phase == 0) begin
				// result side blocked while requests keep coming, so the input backs up
				ready_hold_cycles = 400;
				for (int k = 0; k < 24; k++)
					send_event(CODE_W'($urandom_range(65535)), 1'b0, 1'($urandom_range(1)));
			end
			if (phase == 1) begin
				random_traffic(RANDOM_PER_PHASE / 2);
				wait_drained();
				random_traffic(RANDOM_PER_PHASE / 2);
			end else begin
				random_traffic(RANDOM_PER_PHASE);
			end
			wait_drained();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (board.close_out() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
